[src/blr_pkg.sv]
// Package for the line rasterizer: field widths, register indexes, reset values
// and operation codes.
// No dependencies; used by the rasterizer top level and its checker.
package blr_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int PIX_W    = 16;
    localparam int OFFSET_W = 28;
    localparam int COLOR_W  = 32;

    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 13;
    localparam int STRIDE_W = 17;
    localparam int BPP_W    = 4;
    localparam int CFG_W    = 17;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 96;

    localparam int PX_LSB  = 0;
    localparam int PY_LSB  = 16;
    localparam int OFF_LSB = 32;
    localparam int COL_LSB = 60;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd768;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 17'd4096;
    localparam logic [BPP_W-1:0]    BPP_RST    = 4'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_LINE_STRIDE     = 2'd2,
        CFG_BYTES_PER_PIXEL = 2'd3
    } t_cfg_idx;

endpackage

[src/bresenham_line_rasterizer.sv]
// Bresenham line rasterizer: one load transfer sets up a line, each step
// transfer while the line is unfinished emits one pixel, registered and shown
// in the cycle after its step. One item per clock is sustained while the sink
// accepts; the output register is freed in the same cycle it is taken, so input
// and output run back to back. The line state update is the only loop.
// Synchronous active-low reset clears the line state and loads the register
// defaults (1024 x 768, stride 4096, 4 bytes per pixel). Depends on blr_pkg.
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48], line_color[95:64]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // operation[0]
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // pixel_x[15:0], pixel_y[31:16], byte_offset[59:32], pixel_color[91:60], zero[95:92]
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // on_image[0]
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    localparam int ERR_W = COORD_BITS + 2;
    localparam int CMP_W = ((COORD_BITS > WIDTH_W) ? COORD_BITS : WIDTH_W) + 1;

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [STRIDE_W-1:0] r_line_stride;
    logic [BPP_W-1:0]    r_bytes_per_pixel;

    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_major_end, n_major_end;
    logic [COORD_BITS-1:0]        r_delta_x, n_delta_x;
    logic [COORD_BITS-1:0]        r_delta_y, n_delta_y;
    logic signed [ERR_W-1:0]      r_error_acc, n_error_acc;
    logic                         r_step_x_neg, n_step_x_neg;
    logic                         r_step_y_neg, n_step_y_neg;
    logic                         r_x_major, n_x_major;
    logic                         r_busy, n_busy;
    logic [COLOR_W-1:0]           r_held_color, n_held_color;

    logic                 r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;
    logic                 r_m_user, n_m_user;
    logic                 r_m_last, n_m_last;

    logic                         w_accept;
    logic signed [COORD_BITS-1:0] w_sx, w_sy, w_ex, w_ey;
    logic signed [COORD_BITS:0]   w_dx_s, w_dy_s;
    logic [COORD_BITS-1:0]        w_dx_abs, w_dy_abs;
    logic                         w_load_xmaj;

    logic signed [CMP_W-1:0] w_x_cmp, w_y_cmp, w_w_cmp, w_h_cmp;
    logic                    w_on;
    logic                    w_fin;
    logic [29:0]             w_row_off;
    logic [16:0]             w_col_off;
    logic [OFFSET_W-1:0]     w_offset;

    logic signed [ERR_W-1:0]      w_err_dec;
    logic signed [COORD_BITS-1:0] w_x_inc, w_y_inc;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_sx = COORD_BITS'(i_s_tdata[15:0]);
    assign w_sy = COORD_BITS'(i_s_tdata[31:16]);
    assign w_ex = COORD_BITS'(i_s_tdata[47:32]);
    assign w_ey = COORD_BITS'(i_s_tdata[63:48]);

    assign w_dx_s   = (COORD_BITS+1)'(w_ex) - (COORD_BITS+1)'(w_sx);
    assign w_dy_s   = (COORD_BITS+1)'(w_ey) - (COORD_BITS+1)'(w_sy);
    assign w_dx_abs = w_dx_s[COORD_BITS] ? COORD_BITS'(-w_dx_s) : COORD_BITS'(w_dx_s);
    assign w_dy_abs = w_dy_s[COORD_BITS] ? COORD_BITS'(-w_dy_s) : COORD_BITS'(w_dy_s);
    assign w_load_xmaj = w_dx_abs > w_dy_abs;

    assign w_x_cmp = CMP_W'(r_cur_x);
    assign w_y_cmp = CMP_W'(r_cur_y);
    assign w_w_cmp = $signed(CMP_W'(r_image_width));
    assign w_h_cmp = $signed(CMP_W'(r_image_height));
    assign w_on = !w_x_cmp[CMP_W-1] && !w_y_cmp[CMP_W-1]
               && (w_x_cmp < w_w_cmp) && (w_y_cmp < w_h_cmp);

    assign w_row_off = 30'(w_y_cmp[WIDTH_W-1:0]) * 30'(r_line_stride);
    assign w_col_off = 17'(w_x_cmp[WIDTH_W-1:0]) * 17'(r_bytes_per_pixel);
    assign w_offset  = w_on ? (w_row_off[OFFSET_W-1:0] + OFFSET_W'(w_col_off))
                            : '0;

    assign w_fin = r_x_major ? (r_cur_x == r_major_end) : (r_cur_y == r_major_end);

    assign w_err_dec = r_error_acc - $signed(ERR_W'(r_x_major ? r_delta_y : r_delta_x));
    assign w_x_inc   = r_cur_x + (r_step_x_neg ? -COORD_BITS'(1) : COORD_BITS'(1));
    assign w_y_inc   = r_cur_y + (r_step_y_neg ? -COORD_BITS'(1) : COORD_BITS'(1));

    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_major_end  = r_major_end;
        n_delta_x    = r_delta_x;
        n_delta_y    = r_delta_y;
        n_error_acc  = r_error_acc;
        n_step_x_neg = r_step_x_neg;
        n_step_y_neg = r_step_y_neg;
        n_x_major    = r_x_major;
        n_busy       = r_busy;
        n_held_color = r_held_color;
        n_m_valid    = r_m_valid && !i_m_tready;
        n_m_data     = r_m_data;
        n_m_user     = r_m_user;
        n_m_last     = r_m_last;
        if (w_accept) begin
            if (i_s_tuser == OP_LOAD) begin
                n_cur_x      = w_sx;
                n_cur_y      = w_sy;
                n_delta_x    = w_dx_abs;
                n_delta_y    = w_dy_abs;
                n_step_x_neg = w_dx_s[COORD_BITS];
                n_step_y_neg = w_dy_s[COORD_BITS];
                n_x_major    = w_load_xmaj;
                n_major_end  = w_load_xmaj ? w_ex : w_ey;
                n_error_acc  = $signed(ERR_W'((w_load_xmaj ? w_dx_abs : w_dy_abs) >> 1));
                n_held_color = i_s_tdata[95:64];
                n_busy       = 1'b1;
            end else if (r_busy) begin
                n_m_valid = 1'b1;
                n_m_data  = {4'b0, r_held_color, w_offset,
                             PIX_W'(r_cur_y), PIX_W'(r_cur_x)};
                n_m_user  = w_on;
                n_m_last  = w_fin;
                if (w_fin) begin
                    n_busy = 1'b0;
                end else if (r_x_major) begin
                    n_cur_x = w_x_inc;
                    if (w_err_dec[ERR_W-1]) begin
                        n_cur_y     = w_y_inc;
                        n_error_acc = w_err_dec + $signed(ERR_W'(r_delta_x));
                    end else begin
                        n_error_acc = w_err_dec;
                    end
                end else begin
                    n_cur_y = w_y_inc;
                    if (w_err_dec[ERR_W-1]) begin
                        n_cur_x     = w_x_inc;
                        n_error_acc = w_err_dec + $signed(ERR_W'(r_delta_y));
                    end else begin
                        n_error_acc = w_err_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= WIDTH_RST;
            r_image_height    <= HEIGHT_RST;
            r_line_stride     <= STRIDE_RST;
            r_bytes_per_pixel <= BPP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[HEIGHT_W-1:0];
                CFG_LINE_STRIDE:     r_line_stride     <= i_cfg_data[STRIDE_W-1:0];
                CFG_BYTES_PER_PIXEL: r_bytes_per_pixel <= i_cfg_data[BPP_W-1:0];
                default:             r_image_width     <= r_image_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_major_end  <= '0;
            r_delta_x    <= '0;
            r_delta_y    <= '0;
            r_error_acc  <= '0;
            r_step_x_neg <= 1'b0;
            r_step_y_neg <= 1'b0;
            r_x_major    <= 1'b0;
            r_busy       <= 1'b0;
            r_held_color <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_major_end  <= n_major_end;
            r_delta_x    <= n_delta_x;
            r_delta_y    <= n_delta_y;
            r_error_acc  <= n_error_acc;
            r_step_x_neg <= n_step_x_neg;
            r_step_y_neg <= n_step_y_neg;
            r_x_major    <= n_x_major;
            r_busy       <= n_busy;
            r_held_color <= n_held_color;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

endmodule

[src/blr_checker.sv]
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer.
module blr_checker
    import blr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tuser,
    input logic                 o_m_tlast
);

    // A stalled result transfer keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // A clipped pixel carries a zero byte offset.
    a_clip_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[COL_LSB-1:OFF_LSB] == '0)
        else $error("clipped pixel has nonzero offset");

    // A pixel on the image has nonnegative coordinates.
    a_on_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> !o_m_tdata[PY_LSB-1] && !o_m_tdata[OFF_LSB-1])
        else $error("on-image pixel with negative coordinate");

    // A load transfer never produces a result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_LOAD)
            && (!o_m_tvalid || i_m_tready) |=> !o_m_tvalid)
        else $error("load produced a result");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_line_rasterizer: drives line loads and pixel steps,
// predicts pixels in a built-in line walker (directed rows carry their own expected pixels)
// and checks each output transfer. Depends on blr_pkg and the rasterizer RTL only.
module tb_top;
    import blr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        op;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [31:0] color;
    } line_item_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [27:0] offset;
        logic [31:0] color;
        logic        on_img;
        logic        is_last;
    } pixel_t;

    typedef struct {
        line_item_t item;
        bit         typed;
        bit         has_pixel;
        pixel_t     pixel;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    t_cfg_idx             cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    bresenham_line_rasterizer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Line walker state and register mirror.
    int         pen_x, pen_y, major_stop, run_x, run_y, err_term, dir_x, dir_y;
    bit         x_leads, drawing;
    logic [31:0] ink;
    int         img_w, img_h, row_bytes, pix_bytes;

    pixel_t     pixel_q[$];
    dir_row_t   dir_rows[$];

    int src_idle_pct, snk_stall_pct;
    int hold_left;
    bit hold_req;
    int cycles, fail_count, shown;
    int loads_sent, pixels_checked, pixels_on, line_ends, settings_used;

    function automatic void rasterize(input line_item_t it, output bit has_pixel,
                                      output pixel_t pixel);
        int sx, sy, ex, ey, dx, dy;
        bit fin;
        longint acc;
        has_pixel = 1'b0;
        pixel = '0;
        if (it.op == OP_LOAD) begin
            sx = int'($signed(it.sx));
            sy = int'($signed(it.sy));
            ex = int'($signed(it.ex));
            ey = int'($signed(it.ey));
            dx = ex - sx;
            dy = ey - sy;
            dir_x = 1;
            dir_y = 1;
            if (dx < 0) begin
                dx = -dx;
                dir_x = -1;
            end
            if (dy < 0) begin
                dy = -dy;
                dir_y = -1;
            end
            pen_x = sx;
            pen_y = sy;
            run_x = dx;
            run_y = dy;
            x_leads = dx > dy;
            major_stop = x_leads ? ex : ey;
            err_term = (x_leads ? dx : dy) / 2;
            ink = it.color;
            drawing = 1'b1;
        end else if (drawing) begin
            has_pixel = 1'b1;
            pixel.on_img = pen_x >= 0 && pen_y >= 0 && pen_x < img_w && pen_y < img_h;
            fin = x_leads ? (pen_x == major_stop) : (pen_y == major_stop);
            if (pixel.on_img) begin
                acc = longint'(pen_y) * longint'(row_bytes) + longint'(pen_x) * longint'(pix_bytes);
                pixel.offset = acc[27:0];
            end
            pixel.x = pen_x[15:0];
            pixel.y = pen_y[15:0];
            pixel.color = ink;
            pixel.is_last = fin;
            if (fin) begin
                drawing = 1'b0;
            end else if (x_leads) begin
                err_term -= run_y;
                if (err_term < 0) begin
                    pen_y += dir_y;
                    err_term += run_x;
                end
                pen_x += dir_x;
            end else begin
                err_term -= run_x;
                if (err_term < 0) begin
                    pen_x += dir_x;
                    err_term += run_y;
                end
                pen_y += dir_y;
            end
        end
    endfunction

    function automatic dir_row_t row(logic op, int sx, int sy, int ex, int ey, logic [31:0] col,
                                     bit typed, bit has_pixel, int px, int py, int off,
                                     bit on_img, bit is_last);
        dir_row_t r;
        r.item = '{op: op, sx: 16'(sx), sy: 16'(sy), ex: 16'(ex), ey: 16'(ey), color: col};
        r.typed = typed;
        r.has_pixel = has_pixel;
        r.pixel = '{x: 16'(px), y: 16'(py), offset: 28'(off), color: col,
                    on_img: on_img, is_last: is_last};
        return r;
    endfunction

    function automatic int rand_coord();
        logic [15:0] r;
        r = 16'($urandom);
        return int'($signed(r));
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input line_item_t it, input bit typed, input bit typed_has,
                             input pixel_t typed_pixel, output bit produced);
        bit has_pixel;
        pixel_t pixel;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.color, it.ey, it.ex, it.sy, it.sx};
        s_tuser <= it.op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        rasterize(it, has_pixel, pixel);
        if (typed) begin
            has_pixel = typed_has;
            pixel = typed_pixel;
        end
        if (has_pixel) pixel_q.push_back(pixel);
        if (it.op == OP_LOAD) loads_sent++;
        produced = has_pixel;
        @(negedge clk);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pixel_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs(int w, int h, int stride, int bpp);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= CFG_W'(w);
        img_w = w & 'h1FFF;
        @(negedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data <= CFG_W'(h);
        img_h = h & 'h1FFF;
        @(negedge clk);
        cfg_index <= CFG_LINE_STRIDE;
        cfg_data <= CFG_W'(stride);
        row_bytes = stride & 'h1FFFF;
        @(negedge clk);
        cfg_index <= CFG_BYTES_PER_PIXEL;
        cfg_data <= CFG_W'(bpp);
        pix_bytes = bpp & 'hF;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            1: begin
                src_idle_pct = 65;
                snk_stall_pct = 0;
            end
            2: begin
                src_idle_pct = 0;
                snk_stall_pct = 65;
            end
            default: begin
                src_idle_pct = 36;
                snk_stall_pct = 36;
            end
        endcase
    endtask

    task automatic step_line(int count, inout int made);
        line_item_t it;
        bit produced;
        repeat (count) begin
            it = '{op: OP_STEP, sx: 16'($urandom), sy: 16'($urandom), ex: 16'($urandom),
                   ey: 16'($urandom), color: $urandom};
            send_item(it, 1'b0, 1'b0, '0, produced);
            made += int'(produced);
        end
    endtask

    task automatic random_lines(int target);
        int made, sx, sy, ex, ey, len, n;
        line_item_t it;
        bit produced;
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 1) == 0) begin
                sx = int'($urandom_range(0, 2 * img_w + 40)) - 20;
                sy = int'($urandom_range(0, 2 * img_h + 40)) - 20;
            end else begin
                sx = rand_coord();
                sy = rand_coord();
            end
            case ($urandom_range(0, 19))
                0: begin
                    ex = sx;
                    ey = sy;
                end
                1, 2, 3, 4: begin
                    ex = rand_coord();
                    ey = rand_coord();
                end
                default: begin
                    ex = clamp16(sx + int'($urandom_range(0, 80)) - 40);
                    ey = clamp16(sy + int'($urandom_range(0, 80)) - 40);
                end
            endcase
            it = '{op: OP_LOAD, sx: 16'(sx), sy: 16'(sy), ex: 16'(ex), ey: 16'(ey),
                   color: $urandom};
            send_item(it, 1'b0, 1'b0, '0, produced);
            made++;
            len = (ex > sx ? ex - sx : sx - ex);
            if ((ey > sy ? ey - sy : sy - ey) > len) len = (ey > sy ? ey - sy : sy - ey);
            if (len > 60) begin
                n = $urandom_range(1, 40);
            end else begin
                case ($urandom_range(0, 6))
                    0: n = $urandom_range(0, len);
                    1: n = len + 1 + $urandom_range(1, 3);
                    default: n = len + 1;
                endcase
            end
            step_line(n, made);
        end
    endtask

    always @(negedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge clk) begin
        pixel_t want;
        bit bad;
        if (rst_n && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                fail_count++;
                if (shown < 10) begin
                    shown++;
                    $display("Unexpected pixel transfer: x=%0d y=%0d off=%h col=%h on=%b last=%b",
                             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tdata[59:32],
                             m_tdata[91:60], m_tuser, m_tlast);
                end
            end else begin
                want = pixel_q.pop_front();
                pixels_checked++;
                pixels_on += int'(want.on_img);
                line_ends += int'(want.is_last);
                bad = (m_tdata[15:0] !== want.x) || (m_tdata[31:16] !== want.y)
                    || (m_tdata[59:32] !== want.offset) || (m_tdata[91:60] !== want.color)
                    || (m_tdata[95:92] !== 4'd0) || (m_tuser !== want.on_img)
                    || (m_tlast !== want.is_last);
                if (bad) begin
                    fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("Pixel mismatch: expected x=%0d y=%0d off=%h col=%h on=%b last=%b",
                                 $signed(want.x), $signed(want.y), want.offset, want.color,
                                 want.on_img, want.is_last);
                        $display("                got      x=%0d y=%0d off=%h col=%h on=%b last=%b pad=%h",
                                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                                 m_tdata[59:32], m_tdata[91:60], m_tuser, m_tlast,
                                 m_tdata[95:92]);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d pixels outstanding.",
                     cycles, pixel_q.size());
            $display("FAIL bresenham_line_rasterizer");
            $finish;
        end
    end

    initial begin
        int made;
        bit produced;
        line_item_t it;
        img_w = int'(WIDTH_RST);
        img_h = int'(HEIGHT_RST);
        row_bytes = int'(STRIDE_RST);
        pix_bytes = int'(BPP_RST);
        pen_x = 0;
        pen_y = 0;
        major_stop = 0;
        run_x = 0;
        run_y = 0;
        err_term = 0;
        dir_x = 1;
        dir_y = 1;
        x_leads = 1'b0;
        drawing = 1'b0;
        ink = '0;
        set_idling(0);

        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 1, 1));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_LOAD, -32768, -32768, -32766, -32768, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 1, 1, -32768, -32768, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_LOAD, 1023, 767, 1024, 768, 32'hA5A5_5A5A, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'hA5A5_5A5A, 1, 1, 1023, 767, 3145724, 1, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'hA5A5_5A5A, 1, 1, 1024, 768, 0, 0, 1));
        dir_rows.push_back(row(OP_LOAD, 32767, 32767, 32760, 32764, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h1234_5678, 1, 1, 32767, 32767, 0, 0, 0));
        repeat (3) dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_LOAD, 5, 5, 5, -2, 32'h0F0F_0F0F, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0F0F_0F0F, 1, 1, 5, 5, 20500, 1, 0));
        repeat (3) dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_LOAD, 10, 20, 13, 29, 32'h8000_0001, 0, 0, 0, 0, 0, 0, 0));
        repeat (3) dir_rows.push_back(row(OP_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].has_pixel,
                      dir_rows[i].pixel, produced);
        stop_and_drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: ;
                1: program_regs(4096, 4096, 65536, 8);
                2: program_regs(1, 1, 1, 1);
                3: program_regs(0, 4096, 77, 15);
                4: program_regs('h1FFFF, 8191, 'h1FFFF, 0);
                default: program_regs($urandom_range(1, 4096), $urandom_range(1, 4096),
                                      $urandom_range(1, 65536), $urandom_range(1, 8));
            endcase
            set_idling(p % 4);
            if (p == 0) begin
                // The sink holds off while a long line streams in, so the input backs up.
                hold_req = 1'b1;
                it = '{op: OP_LOAD, sx: 16'(0), sy: 16'(10), ex: 16'(119), ey: 16'(40),
                       color: $urandom};
                send_item(it, 1'b0, 1'b0, '0, produced);
                made = 0;
                step_line(120, made);
            end
            random_lines(190);
            stop_and_drain();
        end

        repeat (8) @(negedge clk);
        fail_count += pixel_q.size();
        $display("Covered %0d line loads and %0d checked pixels (%0d on the image, %0d line ends)",
                 loads_sent, pixels_checked, pixels_on, line_ends);
        $display("across %0d register settings besides reset, with %0d mismatches in %0d cycles.",
                 settings_used, fail_count, cycles);
        if (fail_count == 0) begin
            $display("PASS bresenham_line_rasterizer");
        end else begin
            $display("FAIL bresenham_line_rasterizer");
        end
        $finish;
    end

endmodule
